### hdl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked property checked also during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/wsi_pkg.sv
// ----------------------------------------------------------------------------
// wsi_pkg
// shared types, constants and helpers of the wheel spin integrator
// ----------------------------------------------------------------------------
package wsi_pkg;

    // fixed-point layout
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int CFG_W     = 31;
    localparam int TS_W      = 24;
    localparam int BRAKE_W   = 33;
    localparam int NET_W     = 49;
    localparam int ROLL_W    = 49;
    localparam int NEXT_W    = 54;

    // restoring divider geometry
    localparam int DIV_STEPS = 50;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_REM_W = 32;

    // near-zero threshold, 1e-4 in q16.16
    localparam logic signed [DATA_W-1:0] EPS_RAW = 32'sd7;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_RADIUS    = 2'd0,
        CFG_INERTIA   = 2'd1,
        CFG_TIME_STEP = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] spin_rate;
        logic signed [DATA_W-1:0] road_speed;
        logic signed [DATA_W-1:0] drive_torque;
        logic signed [DATA_W-1:0] service_brake_torque;
        logic signed [DATA_W-1:0] park_brake_torque;
        logic signed [DATA_W-1:0] tire_force;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] next_spin_rate;
        logic                     wheel_locked;
    } t_out;

    // per-item values carried alongside the dividers
    typedef struct packed {
        logic signed [DATA_W-1:0] w;
        logic signed [DATA_W-1:0] td;
        logic [BRAKE_W-1:0]       brake;
        logic                     dir_pos;
        logic                     dir_neg;
        logic                     lockst;
        logic                     net_neg;
        logic                     v_neg;
        logic                     ovf;
    } t_side;

    // one lane of the restoring divider
    typedef struct packed {
        logic [DIV_REM_W-1:0] rem;
        logic [DIV_STEPS-1:0] low;
        logic [DIV_STEPS-1:0] quo;
    } t_div_lane;

    function automatic logic near_zero(logic signed [DATA_W-1:0] x);
        return (x >= -EPS_RAW) && (x <= EPS_RAW);
    endfunction

    // one quotient bit: shift in next numerator bit, subtract if it fits
    function automatic t_div_lane div_step(t_div_lane s, logic [CFG_W-1:0] d);
        logic [DIV_REM_W:0] t;
        logic               ge;
        t_div_lane          r;
        t     = {s.rem, s.low[DIV_STEPS-1]};
        ge    = t >= {2'b00, d};
        r.rem = ge ? DIV_REM_W'(t - {2'b00, d}) : t[DIV_REM_W-1:0];
        r.low = {s.low[DIV_STEPS-2:0], 1'b0};
        r.quo = {s.quo[DIV_STEPS-2:0], ge};
        return r;
    endfunction

endpackage

### hdl/wsi_front.sv
// ----------------------------------------------------------------------------
// wsi_front
// input stages: brake sum, lock check, tire torque, net torque, step product
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsi_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  wsi_pkg::t_in                    i_data,
    input  logic [wsi_pkg::CFG_W-1:0]       i_radius,
    input  logic [wsi_pkg::CFG_W-1:0]       i_inertia,
    input  logic [wsi_pkg::TS_W-1:0]        i_time_step,
    output logic                            o_valid,
    output wsi_pkg::t_side                  o_side,
    output logic [wsi_pkg::DIV_NUM_W-1:0]   o_num_roll,
    output logic [wsi_pkg::DIV_NUM_W-1:0]   o_num_step
);
    import wsi_pkg::*;

    // stage 1: input capture
    logic r1_valid;
    t_in  r1_data;

    // stage 2
    logic                     r2_valid;
    logic signed [DATA_W-1:0] r2_w, r2_td;
    logic [BRAKE_W-1:0]       r2_brake;
    logic                     r2_dir_pos, r2_dir_neg, r2_lockst;
    logic signed [63:0]       r2_prod;
    logic [DATA_W-1:0]        r2_vabs;
    logic                     r2_vneg;

    // stage 3
    logic                     r3_valid;
    logic signed [DATA_W-1:0] r3_w, r3_td;
    logic [BRAKE_W-1:0]       r3_brake;
    logic                     r3_dir_pos, r3_dir_neg, r3_lockst;
    logic signed [NET_W-1:0]  r3_net;
    logic [DATA_W-1:0]        r3_vabs;
    logic                     r3_vneg;

    // stage 4
    logic                     r4_valid;
    logic signed [DATA_W-1:0] r4_w, r4_td;
    logic [BRAKE_W-1:0]       r4_brake;
    logic                     r4_dir_pos, r4_dir_neg, r4_lockst, r4_net_neg;
    logic [47:0]              r4_pl, r4_ph;
    logic [DATA_W-1:0]        r4_vabs;
    logic                     r4_vneg;

    // stage 5: outputs
    logic                     r5_valid;
    t_side                    r5_side;
    logic [DIV_NUM_W-1:0]     r5_num_roll, r5_num_step;

    // stage 2 logic
    logic [DATA_W-1:0]        sb_pos, pb_pos;
    logic [BRAKE_W-1:0]       n2_brake;
    logic                     n2_dir_pos, n2_dir_neg, n2_lockst;
    logic signed [63:0]       n2_prod;
    logic [DATA_W-1:0]        n2_vabs;

    always_comb begin
        sb_pos   = r1_data.service_brake_torque[DATA_W-1] ? '0
                                                          : r1_data.service_brake_torque;
        pb_pos   = r1_data.park_brake_torque[DATA_W-1] ? '0 : r1_data.park_brake_torque;
        n2_brake = {1'b0, sb_pos} + {1'b0, pb_pos};
        n2_lockst = (n2_brake != '0) && near_zero(r1_data.spin_rate)
                    && near_zero(r1_data.road_speed) && near_zero(r1_data.drive_torque)
                    && near_zero(r1_data.tire_force);
        // brake direction from spin, else from road speed
        if (r1_data.spin_rate != '0) begin
            n2_dir_pos = !r1_data.spin_rate[DATA_W-1];
            n2_dir_neg = r1_data.spin_rate[DATA_W-1];
        end else begin
            n2_dir_pos = !r1_data.road_speed[DATA_W-1] && (r1_data.road_speed != '0);
            n2_dir_neg = r1_data.road_speed[DATA_W-1];
        end
        n2_prod = 64'(r1_data.tire_force) * 64'($signed({1'b0, i_radius}));
        n2_vabs = r1_data.road_speed[DATA_W-1] ? (~r1_data.road_speed + 32'd1)
                                               : r1_data.road_speed;
    end

    // stage 3 logic: tire torque truncated toward zero, net torque
    logic signed [63:0]      bias_prod;
    logic signed [47:0]      tire_tq;
    logic signed [NET_W-1:0] brake_term;
    logic signed [NET_W-1:0] n3_net;

    always_comb begin
        bias_prod  = r2_prod + (r2_prod[63] ? 64'sd65535 : 64'sd0);
        tire_tq    = 48'(bias_prod >>> FRAC_BITS);
        brake_term = '0;
        if (r2_dir_pos) begin
            brake_term = $signed({16'd0, r2_brake});
        end else if (r2_dir_neg) begin
            brake_term = -$signed({16'd0, r2_brake});
        end
        n3_net = NET_W'(r2_td) - NET_W'(tire_tq) - brake_term;
    end

    // stage 4 logic: |net| times time step in two partial products
    logic [NET_W-1:0] net_abs;
    logic [47:0]      n4_pl, n4_ph;

    always_comb begin
        net_abs = r3_net[NET_W-1] ? NET_W'(-r3_net) : NET_W'(r3_net);
        n4_pl   = {24'd0, net_abs[23:0]} * {24'd0, i_time_step};
        n4_ph   = {24'd0, net_abs[47:24]} * {24'd0, i_time_step};
    end

    // stage 5 logic: sum partials, drop the 2^8 scale, overflow check
    logic [71:0]          full_prod;
    t_side                n5_side;

    always_comb begin
        full_prod       = {24'd0, r4_pl} + {r4_ph, 24'd0};
        n5_side.w       = r4_w;
        n5_side.td      = r4_td;
        n5_side.brake   = r4_brake;
        n5_side.dir_pos = r4_dir_pos;
        n5_side.dir_neg = r4_dir_neg;
        n5_side.lockst  = r4_lockst;
        n5_side.net_neg = r4_net_neg;
        n5_side.v_neg   = r4_vneg;
        n5_side.ovf     = {17'd0, full_prod[71:58]} >= i_inertia;
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_data     <= i_data;

            r2_w        <= r1_data.spin_rate;
            r2_td       <= r1_data.drive_torque;
            r2_brake    <= n2_brake;
            r2_dir_pos  <= n2_dir_pos;
            r2_dir_neg  <= n2_dir_neg;
            r2_lockst   <= n2_lockst;
            r2_prod     <= n2_prod;
            r2_vabs     <= n2_vabs;
            r2_vneg     <= r1_data.road_speed[DATA_W-1];

            r3_w        <= r2_w;
            r3_td       <= r2_td;
            r3_brake    <= r2_brake;
            r3_dir_pos  <= r2_dir_pos;
            r3_dir_neg  <= r2_dir_neg;
            r3_lockst   <= r2_lockst;
            r3_net      <= n3_net;
            r3_vabs     <= r2_vabs;
            r3_vneg     <= r2_vneg;

            r4_w        <= r3_w;
            r4_td       <= r3_td;
            r4_brake    <= r3_brake;
            r4_dir_pos  <= r3_dir_pos;
            r4_dir_neg  <= r3_dir_neg;
            r4_lockst   <= r3_lockst;
            r4_net_neg  <= r3_net[NET_W-1];
            r4_pl       <= n4_pl;
            r4_ph       <= n4_ph;
            r4_vabs     <= r3_vabs;
            r4_vneg     <= r3_vneg;

            r5_side     <= n5_side;
            r5_num_roll <= {16'd0, r4_vabs, 16'd0};
            r5_num_step <= full_prod[71:8];
        end
    end

    assign o_valid    = r5_valid;
    assign o_side     = r5_side;
    assign o_num_roll = r5_num_roll;
    assign o_num_step = r5_num_step;

    `ASSERT_PROP(a_standing_lock_braked, i_clk, i_rst_n, (r2_valid && r2_lockst) |-> (r2_brake != '0), "standing lock without brake torque")

endmodule

### hdl/wsi_divider.sv
// ----------------------------------------------------------------------------
// wsi_divider
// two-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module wsi_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  wsi_pkg::t_side                  i_side,
    input  logic [wsi_pkg::DIV_NUM_W-1:0]   i_num_a,
    input  logic [wsi_pkg::DIV_NUM_W-1:0]   i_num_b,
    input  logic [wsi_pkg::CFG_W-1:0]       i_den_a,
    input  logic [wsi_pkg::CFG_W-1:0]       i_den_b,
    output logic                            o_valid,
    output wsi_pkg::t_side                  o_side,
    output logic [wsi_pkg::DIV_STEPS-1:0]   o_quo_a,
    output logic [wsi_pkg::DIV_STEPS-1:0]   o_quo_b
);
    import wsi_pkg::*;

    logic      r_valid [DIV_STEPS];
    t_side     r_side  [DIV_STEPS];
    t_div_lane r_lane_a [DIV_STEPS];
    t_div_lane r_lane_b [DIV_STEPS];

    // lane state entering the first stage
    t_div_lane start_a, start_b;

    always_comb begin
        start_a.rem = DIV_REM_W'(i_num_a[DIV_NUM_W-1:DIV_STEPS]);
        start_a.low = i_num_a[DIV_STEPS-1:0];
        start_a.quo = '0;
        start_b.rem = DIV_REM_W'(i_num_b[DIV_NUM_W-1:DIV_STEPS]);
        start_b.low = i_num_b[DIV_STEPS-1:0];
        start_b.quo = '0;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
        logic      src_valid;
        t_side     src_side;
        t_div_lane src_a, src_b;

        // stage source: ports for the first stage, previous stage otherwise
        if (k == 0) begin : g_first
            assign src_valid = i_valid;
            assign src_side  = i_side;
            assign src_a     = start_a;
            assign src_b     = start_b;
        end else begin : g_next
            assign src_valid = r_valid[k-1];
            assign src_side  = r_side[k-1];
            assign src_a     = r_lane_a[k-1];
            assign src_b     = r_lane_b[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= src_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k]   <= src_side;
                r_lane_a[k] <= div_step(src_a, i_den_a);
                r_lane_b[k] <= div_step(src_b, i_den_b);
            end
        end
    end

    assign o_valid = r_valid[DIV_STEPS-1];
    assign o_side  = r_side[DIV_STEPS-1];
    assign o_quo_a = r_lane_a[DIV_STEPS-1].quo;
    assign o_quo_b = r_lane_b[DIV_STEPS-1].quo;

endmodule

### hdl/wsi_resolve.sv
// ----------------------------------------------------------------------------
// wsi_resolve
// euler update, lock and crossing rules, rolling-speed bound, saturation
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsi_resolve (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  wsi_pkg::t_side                  i_side,
    input  logic [wsi_pkg::DIV_STEPS-1:0]   i_quo_roll,
    input  logic [wsi_pkg::DIV_STEPS-1:0]   i_quo_step,
    output logic                            o_valid,
    output wsi_pkg::t_out                   o_data
);
    import wsi_pkg::*;

    localparam logic signed [NEXT_W-1:0] MAX_V = NEXT_W'(64'sh7FFFFFFF);
    localparam logic signed [NEXT_W-1:0] MIN_V = -MAX_V - NEXT_W'(1);

    // stage 1: signed rolling speed and raw euler step
    logic                     r1_valid;
    t_side                    r1_side;
    logic signed [ROLL_W-1:0] r1_roll;
    logic signed [NEXT_W-1:0] r1_next;

    logic signed [ROLL_W-1:0] n1_roll;
    logic [DIV_STEPS:0]       dmag;
    logic signed [NEXT_W-1:0] wx1, dmx, n1_next;

    always_comb begin
        n1_roll = i_side.v_neg ? ROLL_W'(-$signed({1'b0, i_quo_roll}))
                               : ROLL_W'($signed({1'b0, i_quo_roll}));
        dmag    = i_side.ovf ? {1'b1, {DIV_STEPS{1'b0}}} : {1'b0, i_quo_step};
        wx1     = NEXT_W'(i_side.w);
        dmx     = $signed({3'd0, dmag});
        n1_next = i_side.net_neg ? (wx1 - dmx) : (wx1 + dmx);
    end

    // stage 2: brake lock and crossing rules
    logic                     r2_valid;
    logic                     r2_locked, r2_lockst;
    logic signed [DATA_W-1:0] r2_w, r2_td;
    logic signed [ROLL_W-1:0] r2_roll;
    logic signed [NEXT_W-1:0] r2_next;

    logic signed [NEXT_W-1:0] wx, rx, nx, n2_next;
    logic signed [33:0]       td34, br34;
    logic                     brake_nz, has_dir, w_pos, w_neg, n_pos, n_neg;
    logic                     td_ok, n2_locked, td_pos, td_neg;

    always_comb begin
        wx       = NEXT_W'(r1_side.w);
        rx       = NEXT_W'(r1_roll);
        nx       = r1_next;
        td34     = 34'(r1_side.td);
        br34     = $signed({1'b0, r1_side.brake});
        brake_nz = r1_side.brake != '0;
        has_dir  = r1_side.dir_pos || r1_side.dir_neg;
        w_pos    = (wx > 0);
        w_neg    = (wx < 0);
        n_pos    = (nx > 0);
        n_neg    = (nx < 0);
        td_pos   = (r1_side.td > 0);
        td_neg   = (r1_side.td < 0);
        td_ok    = r1_side.dir_pos ? (td34 <= br34) : (-td34 <= br34);
        n2_next  = nx;
        n2_locked = 1'b0;
        if (brake_nz && has_dir) begin
            // brakes stop the wheel instead of carrying it through zero
            if (td_ok && ((w_pos && n_neg) || (w_neg && n_pos)
                || (near_zero(r1_side.w) && (r1_side.dir_pos ? !n_pos : !n_neg)))) begin
                n2_next   = '0;
                n2_locked = 1'b1;
            end
            // brakes never carry the wheel past rolling speed
            if (r1_side.dir_pos) begin
                if (wx <= rx && n2_next > rx) n2_next = rx;
            end else begin
                if (wx >= rx && n2_next < rx) n2_next = rx;
            end
        end else if (!brake_nz) begin
            // drive against spin stops at zero
            if (((td_pos && w_neg) || (td_neg && w_pos)) &&
                ((w_pos && n_neg) || (w_neg && n_pos))) begin
                n2_next = '0;
            end
            if (td_pos) begin
                if (wx >= rx && n2_next < rx) n2_next = rx;
            end else if (td_neg) begin
                if (wx <= rx && n2_next > rx) n2_next = rx;
            end else begin
                if ((wx > rx && n2_next < rx) || (wx < rx && n2_next > rx)) n2_next = rx;
            end
        end
    end

    // stage 3: one-sided bound, saturation, standing lock override
    logic                     r3_valid;
    t_out                     r3_data;

    logic signed [NEXT_W-1:0] wx3, rx3, lim, nb;
    logic                     spin_up;
    t_out                     n3_data;

    always_comb begin
        wx3     = NEXT_W'(r2_w);
        rx3     = NEXT_W'(r2_roll);
        nb      = r2_next;
        spin_up = (rx3 >= 0) ? (r2_td > 0) : (r2_td < 0);
        lim     = '0;
        if (!spin_up) begin
            if (rx3 >= 0) begin
                lim = (wx3 > rx3) ? wx3 : rx3;
                if (nb > lim) nb = lim;
            end else begin
                lim = (wx3 < rx3) ? wx3 : rx3;
                if (nb < lim) nb = lim;
            end
        end
        if (nb > MAX_V) nb = MAX_V;
        if (nb < MIN_V) nb = MIN_V;
        if (r2_lockst) begin
            n3_data.next_spin_rate = '0;
            n3_data.wheel_locked   = 1'b1;
        end else begin
            n3_data.next_spin_rate = nb[DATA_W-1:0];
            n3_data.wheel_locked   = r2_locked;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side   <= i_side;
            r1_roll   <= n1_roll;
            r1_next   <= n1_next;
            r2_locked <= n2_locked;
            r2_lockst <= r1_side.lockst;
            r2_w      <= r1_side.w;
            r2_td     <= r1_side.td;
            r2_roll   <= r1_roll;
            r2_next   <= n2_next;
            r3_data   <= n3_data;
        end
    end

    assign o_valid = r3_valid;
    assign o_data  = r3_data;

    `ASSERT_PROP(a_lock_zero, i_clk, i_rst_n, (r3_valid && r3_data.wheel_locked) |-> (r3_data.next_spin_rate == '0), "locked wheel with nonzero spin")

endmodule

### hdl/wheel_spin_integrator.sv
// ----------------------------------------------------------------------------
// wheel_spin_integrator
// one euler step of a wheel's spin rate per item, q16.16 fixed point
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  input     in         i_valid / o_stall     i_data (t_in)
//  result    out        o_valid / i_stall     o_data (t_out)
//  config    in         i_cfg_we              i_cfg_index, i_cfg_data
//
//  one item per cycle while no result is stalled: 5 front stages, 50
//  stages of restoring division (one quotient bit each), 3 resolve stages
//  synchronous active-low reset clears the valid bits and loads the
//  register defaults; no clearing pass
//  a stalled result freezes the whole pipeline; o_stall follows i_stall
//  while a result is held
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wheel_spin_integrator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  wsi_pkg::t_in                i_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output wsi_pkg::t_out               o_data,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [wsi_pkg::CFG_W-1:0]   i_cfg_data
);
    import wsi_pkg::*;

    // configuration registers
    logic [CFG_W-1:0] r_radius, r_inertia;
    logic [TS_W-1:0]  r_time_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= CFG_W'(21627);
            r_inertia   <= CFG_W'(65536);
            r_time_step <= TS_W'(139810);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RADIUS:    r_radius    <= i_cfg_data;
                CFG_INERTIA:   r_inertia   <= i_cfg_data;
                CFG_TIME_STEP: r_time_step <= i_cfg_data[TS_W-1:0];
                default: ;
            endcase
        end
    end

    // zero radius and inertia count as one lsb
    logic [CFG_W-1:0] radius_eff, inertia_eff;
    assign radius_eff  = (r_radius == '0) ? CFG_W'(1) : r_radius;
    assign inertia_eff = (r_inertia == '0) ? CFG_W'(1) : r_inertia;

    // global advance: move unless a held result is stalled
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    logic                 fr_valid;
    t_side                fr_side;
    logic [DIV_NUM_W-1:0] fr_num_roll, fr_num_step;

    wsi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .i_radius    (radius_eff),
        .i_inertia   (inertia_eff),
        .i_time_step (r_time_step),
        .o_valid     (fr_valid),
        .o_side      (fr_side),
        .o_num_roll  (fr_num_roll),
        .o_num_step  (fr_num_step)
    );

    logic                 dv_valid;
    t_side                dv_side;
    logic [DIV_STEPS-1:0] dv_quo_roll, dv_quo_step;

    wsi_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_side  (fr_side),
        .i_num_a (fr_num_roll),
        .i_num_b (fr_num_step),
        .i_den_a (radius_eff),
        .i_den_b (inertia_eff),
        .o_valid (dv_valid),
        .o_side  (dv_side),
        .o_quo_a (dv_quo_roll),
        .o_quo_b (dv_quo_step)
    );

    wsi_resolve u_resolve (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (dv_valid),
        .i_side     (dv_side),
        .i_quo_roll (dv_quo_roll),
        .i_quo_step (dv_quo_step),
        .o_valid    (o_valid),
        .o_data     (o_data)
    );

    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")
    `ASSERT_PROP(a_stall_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_data)), "stalled result changed")

endmodule
